// ===== sv/row_descending_sorter_assert.svh =====
// Assertion macros shared by the sorter RTL.
// These macros expect clk and arst_n to be visible where they are used.
`ifndef ROW_DESCENDING_SORTER_ASSERT_SVH
`define ROW_DESCENDING_SORTER_ASSERT_SVH

`ifndef SYNTHESIS
`define RDS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("sorter assertion failed");
`define RDS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorter assertion failed");
`define RDS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorter assertion failed");
`else
`define RDS_ASSERT(label, prop)
`define RDS_ASSERT_IMPL(label, ante, cons)
`define RDS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/rds_pkg.sv =====
package rds_pkg;

	localparam int ELEM_W      = 32;
	localparam int LEN_W       = 5;
	localparam int ROW_MAX_DEF = 16;
	localparam logic [LEN_W-1:0] ROW_LENGTH_RST = LEN_W'(16);

	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef struct packed {
		elem_t element_value;
	} in_payload_t;

	typedef struct packed {
		elem_t sorted_value;
		logic  row_end;
	} out_payload_t;

	typedef struct packed {
		logic [LEN_W-1:0] row_length;
	} cfg_payload_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;    // insert the broadcast element
		logic shift;  // move every entry one cell toward the head
		logic clear;  // drop all entries
	} cell_ctrl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

endpackage

// ===== sv/rds_stream_if.sv =====
interface rds_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rds_cell.sv =====
module rds_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  rds_pkg::cell_ctrl_t ctrl,
	input  rds_pkg::elem_t      bcast_value,
	input  logic                prev_take,
	input  rds_pkg::elem_t      prev_value,
	input  logic                prev_valid,
	input  rds_pkg::elem_t      next_value,
	input  logic                next_valid,
	output rds_pkg::elem_t      value,
	output logic                valid,
	output logic                take
);
	import rds_pkg::*;

	elem_t value_q;
	logic  valid_q;

	// The chain is kept in decreasing order from the head, so the new element
	// belongs in the first cell that is empty or holds a smaller value.
	assign take  = !valid_q || (bcast_value > value_q);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (ctrl.ins) begin
			valid_q <= prev_take ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next_value;
		end else if (ctrl.ins) begin
			if (prev_take) begin
				value_q <= prev_value;
			end else if (take) begin
				value_q <= bcast_value;
			end
		end
	end
endmodule

// ===== sv/row_descending_sorter.sv =====
// Once the last element of a row is accepted, the block drains the row: the
// largest value of that row is the first to appear on results.
// One element per cycle is accepted while a row loads, then one result per
// cycle while it drains and results is not stalled; no element is taken then.
// Reset (arst_n low, asynchronous) empties the cell chain, clears the fill
// count and the output register, and sets row_length to 16.
`include "row_descending_sorter_assert.svh"

module row_descending_sorter #(
	parameter int ROW_MAX = rds_pkg::ROW_MAX_DEF
) (
	input logic        clk,
	input logic        arst_n,
	rds_stream_if.sink   cfg,
	rds_stream_if.sink   elements,
	rds_stream_if.source results
);
	import rds_pkg::*;

	// Counts reach the effective row length itself, hence the extra value.
	localparam int CNT_W = $clog2(ROW_MAX + 1);
	localparam logic [CNT_W-1:0] ROW_MAX_CNT = CNT_W'(ROW_MAX);

	// The sorting structure is a row of ROW_MAX identical cells. Every
	// element is broadcast to all cells; each cell decides from its own value
	// and its upper neighbor's decision whether it keeps its entry, takes the
	// new element, or takes the entry pushed down from above. The chain thus
	// always holds the row loaded so far in decreasing order. To emit a row
	// the chain shifts toward the head once per result.

	state_t state_q, state_d;

	logic [LEN_W-1:0] row_length_q;
	logic [CNT_W-1:0] eff_len;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] remain_q;

	logic         out_valid_q;
	elem_t        out_value_q;
	logic         out_end_q;

	cell_ctrl_t   ctrl;
	logic         cfg_write;
	logic         in_accept;
	logic         row_done;
	logic         pop;

	elem_t              cell_value [ROW_MAX];
	logic [ROW_MAX-1:0] cell_valid;
	logic [ROW_MAX-1:0] cell_take;

	// A length of zero behaves as one; a length beyond the chain saturates.
	always_comb begin
		if (row_length_q == '0) begin
			eff_len = CNT_W'(1);
		end else if (32'(row_length_q) > ROW_MAX) begin
			eff_len = ROW_MAX_CNT;
		end else begin
			eff_len = CNT_W'(row_length_q);
		end
	end

	// The register write port never stalls; the user must send writes only while idle, which the block does not enforce.
	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid;

	assign in_accept = elements.valid && elements.ready;
	assign row_done  = in_accept && ((fill_q + 1'b1) == eff_len);
	// During a drain, a result moves into the output register whenever that
	// register is free or its current transaction completes in this cycle.
	assign pop       = (state_q == ST_DRAIN) && (!out_valid_q || results.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (!cfg_write && row_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (pop && remain_q == CNT_W'(1)) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		elements.ready = 1'b0;
		ctrl           = '0;
		ctrl.clear     = cfg_write;
		unique case (state_q)
			ST_LOAD: begin
				elements.ready = 1'b1;
				ctrl.ins       = in_accept && !cfg_write;
			end
			ST_DRAIN: begin
				ctrl.shift = pop;
			end
			default: begin
				elements.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			row_length_q <= ROW_LENGTH_RST;
			fill_q       <= '0;
			remain_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				// A new length discards any partly loaded row.
				row_length_q <= cfg.data.row_length;
				fill_q       <= '0;
			end else if (row_done) begin
				fill_q   <= '0;
				remain_q <= eff_len;
			end else if (in_accept) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop) begin
				remain_q <= remain_q - 1'b1;
			end
		end
	end

	// Output register: it decouples the chain from a stalled consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_value_q <= cell_value[0];
			out_end_q   <= (remain_q == CNT_W'(1));
		end
	end

	assign results.valid             = out_valid_q;
	assign results.data.sorted_value = out_value_q;
	assign results.data.row_end      = out_end_q;

	// The head cell has no upper neighbor and the tail cell has no lower one.
	for (genvar i = 0; i < ROW_MAX; i++) begin : g_cell
		logic  up_take;
		elem_t up_value;
		logic  up_valid;
		elem_t dn_value;
		logic  dn_valid;

		if (i == 0) begin : g_head
			assign up_take  = 1'b0;
			assign up_value = '0;
			assign up_valid = 1'b0;
		end else begin : g_body
			assign up_take  = cell_take[i-1];
			assign up_value = cell_value[i-1];
			assign up_valid = cell_valid[i-1];
		end

		if (i == ROW_MAX - 1) begin : g_tail
			assign dn_value = '0;
			assign dn_valid = 1'b0;
		end else begin : g_inner
			assign dn_value = cell_value[i+1];
			assign dn_valid = cell_valid[i+1];
		end

		rds_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.bcast_value (elements.data.element_value),
			.prev_take   (up_take),
			.prev_value  (up_value),
			.prev_valid  (up_valid),
			.next_value  (dn_value),
			.next_valid  (dn_valid),
			.value       (cell_value[i]),
			.valid       (cell_valid[i]),
			.take        (cell_take[i])
		);
	end

	// Occupied cells always form an unbroken run starting at the head.
	`RDS_ASSERT(a_valid_run, (cell_valid & (cell_valid + 1'b1)) == '0)
	// While loading, the chain holds exactly the elements counted so far.
	`RDS_ASSERT_IMPL(a_fill_match, state_q == ST_LOAD, $countones(cell_valid) == 32'(fill_q))
	// A drain always has results left to emit.
	`RDS_ASSERT_IMPL(a_drain_left, state_q == ST_DRAIN, remain_q != '0)
	// The element that completes a row starts the drain.
	`RDS_ASSERT_NEXT(a_row_to_drain, row_done && !cfg_write, state_q == ST_DRAIN)
	// Each emitted result comes from an occupied head cell.
	`RDS_ASSERT_IMPL(a_pop_valid, pop, cell_valid[0])
endmodule
